// File: src/rpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rpd_pkg;

  localparam int HDR_LEN        = 15;
  localparam int MAX_PACKET_DEF = 4096;
  localparam int NUL_SKIP       = 2;
  localparam int ID_BYTES       = 8;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;

  localparam logic [7:0] TYPE_REPLY = 8'd1;

  typedef enum logic [0:0] {
    REG_LOGIN_CMD = 1'b0
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]         payload_byte;
    logic               byte_valid;
    logic               last;
    logic [7:0]         packet_type;
    logic [15:0]        command;
    logic [63:0]        frame_id;
    logic [7:0]         error_code;
    logic [11:0]        payload_length;
    logic               malformed;
    logic signed [63:0] user_id;
    logic               user_id_updated;
  } result_t;

endpackage
`default_nettype wire

// File: src/rpd_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface rpd_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         payload_byte;
  logic               byte_valid;
  logic               last;
  logic [7:0]         packet_type;
  logic [15:0]        command;
  logic [63:0]        frame_id;
  logic [7:0]         error_code;
  logic [11:0]        payload_length;
  logic               malformed;
  logic signed [63:0] user_id;
  logic               user_id_updated;

  modport source (
    output valid, output payload_byte, output byte_valid, output last,
    output packet_type, output command, output frame_id, output error_code,
    output payload_length, output malformed, output user_id, output user_id_updated,
    input ready
  );
  modport sink (
    input valid, input payload_byte, input byte_valid, input last,
    input packet_type, input command, input frame_id, input error_code,
    input payload_length, input malformed, input user_id, input user_id_updated,
    output ready
  );
endinterface
`default_nettype wire

// File: src/rpd_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
module rpd_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [rpd_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [rpd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [rpd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready,
  output logic      [15:0]                    login_command
);
  import rpd_pkg::*;

  logic [15:0] login_cmd_r;
  logic [15:0] login_cmd_nxt;
  cfg_reg_t    reg_sel;
  logic        wr_en;

  assign reg_sel = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    login_cmd_nxt = login_cmd_r;
    if (wr_en && (reg_sel == REG_LOGIN_CMD)) begin
      login_cmd_nxt = pwdata[15:0];
    end
  end

  always_comb begin
    case (reg_sel)
      REG_LOGIN_CMD: prdata = CFG_DATA_W'(login_cmd_r);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      login_cmd_r <= '0;
    end else begin
      login_cmd_r <= login_cmd_nxt;
    end
  end

  assign login_command = login_cmd_r;

endmodule
`default_nettype wire

// File: src/rpd_core.sv
`timescale 1ns / 1ps
`default_nettype none
module rpd_core #(
  parameter int MAX_PACKET = rpd_pkg::MAX_PACKET_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic [7:0]       in_byte,
  input  wire logic [15:0]      login_command,
  output logic                  res_vld,
  output rpd_pkg::result_t      res
);
  import rpd_pkg::*;

  localparam int POS_W = $clog2(MAX_PACKET);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [15:0]      cmd_r, cmd_nxt;
  logic [31:0]      size_r, size_nxt;
  logic [63:0]      id_r, id_nxt;
  logic [7:0]       err_r, err_nxt;
  logic [1:0]       nul_r, nul_nxt;
  logic [3:0]       cap_r, cap_nxt;
  logic [63:0]      capt_r, capt_nxt;
  logic [63:0]      learned_r, learned_nxt;
  logic             stopped_r, stopped_nxt;

  logic clr;
  logic is_last;
  logic snoop_en;
  logic pb_valid;
  logic last_f;
  logic mal_f;
  logic upd_f;
  logic reply_sub;

  assign is_last  = ({1'b0, 32'(pos_r)} + 33'd1) == {1'b0, size_r};
  assign snoop_en = (type_r == TYPE_REPLY) && (cmd_r == login_command);

  always_comb begin
    pos_nxt     = pos_r;
    type_nxt    = type_r;
    cmd_nxt     = cmd_r;
    size_nxt    = size_r;
    id_nxt      = id_r;
    err_nxt     = err_r;
    nul_nxt     = nul_r;
    cap_nxt     = cap_r;
    capt_nxt    = capt_r;
    learned_nxt = learned_r;
    stopped_nxt = stopped_r;
    clr         = 1'b0;
    res_vld     = 1'b0;
    pb_valid    = 1'b0;
    last_f      = 1'b0;
    mal_f       = 1'b0;
    upd_f       = 1'b0;
    if (step && !stopped_r) begin
      if (pos_r < POS_W'(HDR_LEN)) begin
        // header capture, little-endian
        if (pos_r == '0) begin
          type_nxt = in_byte;
        end
        for (int k = 0; k < 2; k++) begin
          if (pos_r == POS_W'(1 + k)) begin
            cmd_nxt[8*k +: 8] = in_byte;
          end
        end
        for (int k = 0; k < 4; k++) begin
          if (pos_r == POS_W'(3 + k)) begin
            size_nxt[8*k +: 8] = in_byte;
          end
        end
        for (int k = 0; k < 8; k++) begin
          if (pos_r == POS_W'(7 + k)) begin
            id_nxt[8*k +: 8] = in_byte;
          end
        end
        if (pos_r == POS_W'(HDR_LEN - 1)) begin
          if ((size_nxt < 32'(HDR_LEN)) || (size_nxt > 32'(MAX_PACKET))) begin
            stopped_nxt = 1'b1;
            err_nxt     = '0;
            res_vld     = 1'b1;
            mal_f       = 1'b1;
          end else if (size_nxt == 32'(HDR_LEN)) begin
            err_nxt = '0;
            res_vld = 1'b1;
            last_f  = 1'b1;
            clr     = 1'b1;
          end else begin
            pos_nxt = POS_W'(HDR_LEN);
          end
        end else begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end else begin
        if ((type_r == TYPE_REPLY) && (pos_r == POS_W'(HDR_LEN))) begin
          err_nxt = in_byte;
        end else begin
          pb_valid = 1'b1;
          if (snoop_en && (err_r == '0)) begin
            if (nul_r < 2'(NUL_SKIP)) begin
              if (in_byte == '0) begin
                nul_nxt = nul_r + 2'd1;
              end
            end else if (cap_r < 4'(ID_BYTES)) begin
              for (int k = 0; k < ID_BYTES; k++) begin
                if (cap_r[2:0] == 3'(k)) begin
                  capt_nxt[8*k +: 8] = in_byte;
                end
              end
              cap_nxt = cap_r + 4'd1;
            end
          end
        end
        if (is_last) begin
          if (snoop_en && (err_nxt == '0) && (cap_nxt == 4'(ID_BYTES))) begin
            learned_nxt = capt_nxt;
            upd_f       = 1'b1;
          end
          res_vld = 1'b1;
          last_f  = 1'b1;
          clr     = 1'b1;
        end else begin
          pos_nxt = pos_r + POS_W'(1);
          res_vld = pb_valid;
        end
      end
    end
  end

  assign reply_sub = (type_nxt == TYPE_REPLY) && (size_nxt > 32'(HDR_LEN));

  always_comb begin
    res.payload_byte    = pb_valid ? in_byte : '0;
    res.byte_valid      = pb_valid;
    res.last            = last_f;
    res.packet_type     = type_nxt;
    res.command         = cmd_nxt;
    res.frame_id        = id_nxt;
    res.error_code      = mal_f ? '0 : err_nxt;
    res.payload_length  = mal_f ? '0
                        : (size_nxt[11:0] - 12'(HDR_LEN) - {11'd0, reply_sub});
    res.malformed       = mal_f;
    res.user_id         = learned_nxt;
    res.user_id_updated = upd_f;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      type_r    <= '0;
      cmd_r     <= '0;
      size_r    <= '0;
      id_r      <= '0;
      err_r     <= '0;
      nul_r     <= '0;
      cap_r     <= '0;
      capt_r    <= '0;
      learned_r <= '0;
      stopped_r <= 1'b0;
    end else begin
      type_r    <= type_nxt;
      cmd_r     <= cmd_nxt;
      size_r    <= size_nxt;
      id_r      <= id_nxt;
      learned_r <= learned_nxt;
      stopped_r <= stopped_nxt;
      if (clr) begin
        pos_r  <= '0;
        err_r  <= '0;
        nul_r  <= '0;
        cap_r  <= '0;
        capt_r <= '0;
      end else begin
        pos_r  <= pos_nxt;
        err_r  <= err_nxt;
        nul_r  <= nul_nxt;
        cap_r  <= cap_nxt;
        capt_r <= capt_nxt;
      end
    end
  end

  a_stopped_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |=> stopped_r)
    else $error("stopped flag cleared without reset");

  a_no_result_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> !res_vld)
    else $error("result produced after malformed packet");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && res.last) |=> (pos_r == '0) && (cap_r == '0) && (nul_r == '0))
    else $error("packet state not cleared after last word");

  a_malformed_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && res.malformed) |=> stopped_r)
    else $error("malformed result did not stop the deframer");

endmodule
`default_nettype wire

// File: src/rpc_packet_deframer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Packet deframer for a byte-serial RPC link. Takes one stream byte per cycle on in_ch while
// out_ch is not stalled, and gives at most one word per byte on out_ch: one per payload byte,
// one on the final byte of each packet (last set, header fields valid) and one with malformed
// set when a header declares a size below 15 or above MAX_PACKET, after which every byte is
// swallowed until reset. A byte passes through the input register and the result register
// around the single pass of header, error-byte and login-snoop logic. login_command sits at
// byte address 0 of the APB port and should be written while the stream is idle; user_id
// reports the id learned from the latest successful login reply.
module rpc_packet_deframer_top #(
  parameter int MAX_PACKET = rpd_pkg::MAX_PACKET_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  rpd_in_if.sink                              in_ch,
  rpd_out_if.source                           out_ch,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [rpd_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [rpd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [rpd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready
);
  import rpd_pkg::*;

  logic        in_vld_r, in_vld_nxt;
  logic [7:0]  in_byte_r, in_byte_nxt;
  logic        out_vld_r, out_vld_nxt;
  result_t     out_res_r, out_res_nxt;
  logic        advance;
  logic        take;
  logic        res_vld;
  result_t     res;
  logic [15:0] login_command;

  rpd_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .login_command (login_command)
  );

  rpd_core #(
    .MAX_PACKET (MAX_PACKET)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .in_byte       (in_byte_r),
    .login_command (login_command),
    .res_vld       (res_vld),
    .res           (res)
  );

  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    in_vld_nxt  = in_vld_r;
    in_byte_nxt = in_byte_r;
    if (in_ch.ready) begin
      in_vld_nxt  = take;
      in_byte_nxt = in_ch.data_byte;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    out_res_nxt = out_res_r;
    if (advance) begin
      out_vld_nxt = res_vld;
      out_res_nxt = res;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_byte_r <= in_byte_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.payload_byte    = out_res_r.payload_byte;
  assign out_ch.byte_valid      = out_res_r.byte_valid;
  assign out_ch.last            = out_res_r.last;
  assign out_ch.packet_type     = out_res_r.packet_type;
  assign out_ch.command         = out_res_r.command;
  assign out_ch.frame_id        = out_res_r.frame_id;
  assign out_ch.error_code      = out_res_r.error_code;
  assign out_ch.payload_length  = out_res_r.payload_length;
  assign out_ch.malformed       = out_res_r.malformed;
  assign out_ch.user_id         = out_res_r.user_id;
  assign out_ch.user_id_updated = out_res_r.user_id_updated;

endmodule
`default_nettype wire

// File: bench/tb_rpc_packet_deframer_top.sv
`timescale 1ns / 1ps
module tb_rpc_packet_deframer_top;
  import rpd_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam logic [CFG_ADDR_W-1:0] LOGIN_CMD_ADDR = CFG_ADDR_W'(4 * int'(REG_LOGIN_CMD));
  // unmapped register slot
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR = CFG_ADDR_W'(4 * (int'(REG_LOGIN_CMD) + 1));

  class frame_tracker;
    logic [15:0] login_cmd;
    int          pos;
    logic [7:0]  typ;
    logic [15:0] cmd;
    logic [31:0] size;
    logic [63:0] id;
    logic [7:0]  err;
    int          nuls;
    int          caps;
    logic [63:0] cap_id;
    logic [63:0] uid;
    bit          stopped;
    result_t     due_words[$];
    int          mismatches;
    int          words_seen;

    function new();
      login_cmd = '0;
      typ = '0;
      cmd = '0;
      size = '0;
      id = '0;
      uid = '0;
      stopped = 0;
      mismatches = 0;
      words_seen = 0;
      restart();
    endfunction

    function void restart();
      pos = 0;
      err = '0;
      nuls = 0;
      caps = 0;
      cap_id = '0;
    endfunction

    function logic [11:0] body_len();
      logic [31:0] n;
      n = size - HDR_LEN;
      if (typ == TYPE_REPLY && size > HDR_LEN) n = n - 1;
      return n[11:0];
    endfunction

    function void push_word(logic [7:0] pb, bit vld, bit lst, bit mal, bit upd);
      result_t r;
      r.payload_byte    = vld ? pb : 8'h00;
      r.byte_valid      = vld;
      r.last            = lst;
      r.packet_type     = typ;
      r.command         = cmd;
      r.frame_id        = id;
      r.error_code      = mal ? 8'h00 : err;
      r.payload_length  = mal ? 12'h000 : body_len();
      r.malformed       = mal;
      r.user_id         = uid;
      r.user_id_updated = upd;
      due_words.push_back(r);
    endfunction

    function void take_byte(logic [7:0] b);
      int p;
      bit fin;
      bit vld;
      bit upd;
      bit snoop;
      if (stopped) return;
      p = pos;
      if (p < HDR_LEN) begin
        if (p == 0) typ = b;
        else if (p <= 2) cmd[8*(p-1) +: 8] = b;
        else if (p <= 6) size[8*(p-3) +: 8] = b;
        else id[8*(p-7) +: 8] = b;
        if (p < HDR_LEN - 1) begin
          pos = p + 1;
          return;
        end
        if (size < HDR_LEN || size > MAX_PACKET_DEF) begin
          stopped = 1;
          err = '0;
          push_word(8'h00, 0, 0, 1, 0);
          return;
        end
        if (size == HDR_LEN) begin
          err = '0;
          push_word(8'h00, 0, 1, 0, 0);
          restart();
          return;
        end
        pos = HDR_LEN;
        return;
      end
      fin = (p + 1 == size);
      vld = 1;
      upd = 0;
      snoop = (typ == TYPE_REPLY && cmd == login_cmd);
      if (typ == TYPE_REPLY && p == HDR_LEN) begin
        err = b;
        vld = 0;
      end else if (snoop && err == 0) begin
        if (nuls < NUL_SKIP) begin
          if (b == 0) nuls++;
        end else if (caps < ID_BYTES) begin
          cap_id[8*caps +: 8] = b;
          caps++;
        end
      end
      if (fin) begin
        if (snoop && err == 0 && caps == ID_BYTES) begin
          uid = cap_id;
          upd = 1;
        end
        push_word(b, vld, 1, 0, upd);
        restart();
        return;
      end
      pos = p + 1;
      if (vld) push_word(b, 1, 0, 0, 0);
    endfunction

    function void complain(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void match_word(result_t got);
      result_t exp;
      string bad;
      words_seen++;
      if (due_words.size() == 0) begin
        complain($sformatf("word %0d arrived with nothing due: %h", words_seen, got));
        return;
      end
      exp = due_words.pop_front();
      bad = "";
      if (got.payload_byte !== exp.payload_byte) bad = {bad, " payload_byte"};
      if (got.byte_valid !== exp.byte_valid) bad = {bad, " byte_valid"};
      if (got.last !== exp.last) bad = {bad, " last"};
      if (got.packet_type !== exp.packet_type) bad = {bad, " packet_type"};
      if (got.command !== exp.command) bad = {bad, " command"};
      if (got.frame_id !== exp.frame_id) bad = {bad, " frame_id"};
      if (got.error_code !== exp.error_code) bad = {bad, " error_code"};
      if (got.payload_length !== exp.payload_length) bad = {bad, " payload_length"};
      if (got.malformed !== exp.malformed) bad = {bad, " malformed"};
      if (got.user_id !== exp.user_id) bad = {bad, " user_id"};
      if (got.user_id_updated !== exp.user_id_updated) bad = {bad, " user_id_updated"};
      if (bad != "")
        complain($sformatf("word %0d:%s expected %h got %h", words_seen, bad, exp, got));
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  rpd_in_if  in_ch ();
  rpd_out_if out_ch ();

  frame_tracker sb = new();
  int           sent;
  bit           no_gaps;

  rpc_packet_deframer_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  task automatic send_byte(logic [7:0] b);
    int g;
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.data_byte = b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.take_byte(b);
    sent++;
    g = no_gaps ? 0 : idle_len();
    if (g > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      in_ch.data_byte = 8'($urandom);
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic send_frame(logic [7:0] typ, logic [15:0] cmd, logic [31:0] size,
                            logic [63:0] id, byte_q_t body);
    byte_q_t q;
    int k;
    q.push_back(typ);
    q.push_back(cmd[7:0]);
    q.push_back(cmd[15:8]);
    for (k = 0; k < 4; k++) q.push_back(size[8*k +: 8]);
    for (k = 0; k < 8; k++) q.push_back(id[8*k +: 8]);
    foreach (body[j]) q.push_back(body[j]);
    foreach (q[j]) send_byte(q[j]);
  endtask

  // stop sending and wait for every due word
  task automatic settle();
    int i;
    @(negedge clk);
    in_ch.valid = 1'b0;
    i = 0;
    while (sb.due_words.size() > 0 && i < 5000) begin
      @(posedge clk);
      i++;
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic apb_xfer(bit wr, logic [CFG_ADDR_W-1:0] addr, logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = addr;
    pwdata = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_login_cmd(logic [15:0] v);
    logic [31:0] rd;
    settle();
    apb_xfer(1'b1, LOGIN_CMD_ADDR, {16'($urandom), v}, rd);
    sb.login_cmd = v;
    apb_xfer(1'b0, LOGIN_CMD_ADDR, 32'h0, rd);
    if (rd[15:0] !== v) sb.complain($sformatf("login_command read %h, wrote %h", rd, v));
  endtask

  task automatic random_packet();
    logic [7:0]  typ;
    logic [15:0] cmd;
    byte_q_t     body;
    int          shape;
    typ = ($urandom_range(0, 99) < 60) ? TYPE_REPLY : 8'($urandom);
    cmd = ($urandom_range(0, 99) < 60) ? sb.login_cmd : 16'($urandom);
    no_gaps = ($urandom_range(0, 3) == 0);
    if (!(typ == TYPE_REPLY && $urandom_range(0, 15) == 0)) begin
      if (typ == TYPE_REPLY)
        body.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00);
      shape = $urandom_range(0, 9);
      if (shape < 6) begin
        // two nul-terminated strings, the id, then some trailing bytes
        repeat ($urandom_range(0, 3)) body.push_back(8'($urandom_range(1, 255)));
        body.push_back(8'h00);
        repeat ($urandom_range(0, 3)) body.push_back(8'($urandom_range(1, 255)));
        body.push_back(8'h00);
        repeat (ID_BYTES) body.push_back(8'($urandom));
        repeat ($urandom_range(0, 4)) body.push_back(8'($urandom));
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 12)) if (body.size() > 0) void'(body.pop_back());
      end else begin
        repeat ($urandom_range(0, 20))
          body.push_back(($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom));
      end
    end
    send_frame(typ, cmd, 32'(HDR_LEN + body.size()), {$urandom, $urandom}, body);
    if ($urandom_range(0, 24) == 0) settle();
  endtask

  initial begin
    int run;
    out_ch.ready = 1'b0;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 8);
      @(negedge clk);
      out_ch.ready = 1'b1;
      repeat (run - 1) @(negedge clk);
      run = idle_len();
      if (run > 0) begin
        @(negedge clk);
        out_ch.ready = 1'b0;
        repeat (run - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    result_t w;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      w = {out_ch.payload_byte, out_ch.byte_valid, out_ch.last, out_ch.packet_type,
           out_ch.command, out_ch.frame_id, out_ch.error_code, out_ch.payload_length,
           out_ch.malformed, out_ch.user_id, out_ch.user_id_updated};
      sb.match_word(w);
    end
  end

  initial begin
    logic [31:0] rd;
    logic [31:0] sz;
    logic [15:0] phase_cmd[4];
    byte_q_t     none;
    byte_q_t     one;
    int          p;
    int          start;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sent = 0;
    no_gaps = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // header-only packet with every type, command and id bit set, then a reply of just an error byte
    send_frame(8'hFF, 16'hFFFF, 32'(HDR_LEN), 64'hFFFF_FFFF_FFFF_FFFF, none);
    one.push_back(8'hFF);
    send_frame(TYPE_REPLY, 16'h0000, 32'(HDR_LEN + 1), 64'h0, one);
    settle();
    apb_xfer(1'b1, SPARE_ADDR, $urandom, rd);

    phase_cmd = '{16'hFFFF, 16'($urandom), 16'h0000, 16'($urandom)};
    for (p = 0; p < 4; p++) begin
      set_login_cmd(phase_cmd[p]);
      start = sent;
      while (sent - start < 150) random_packet();
    end

    // bad size stops the block for good, so it goes last
    settle();
    case ($urandom_range(0, 3))
      0: sz = 32'h0;
      1: sz = 32'(HDR_LEN - 1);
      2: sz = 32'(MAX_PACKET_DEF + 1);
      default: sz = $urandom | 32'h8000_0000;
    endcase
    no_gaps = 0;
    send_frame(8'($urandom), 16'($urandom), sz, {$urandom, $urandom}, none);
    repeat (20) send_byte(8'($urandom));
    settle();

    if (sb.due_words.size() > 0)
      sb.complain($sformatf("%0d words never arrived", sb.due_words.size()));
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// File: files.f
src/rpd_pkg.sv
src/rpd_if.sv
src/rpd_cfg.sv
src/rpd_core.sv
src/rpc_packet_deframer_top.sv
bench/tb_rpc_packet_deframer_top.sv
